// ===== src/lcm_pkg.sv =====
// Shared types and constants for the letterbox coordinate mapper.
// No dependencies; every other file imports this package.
package lcm_pkg;

  // Default widths, handed to the module parameters
  localparam int COORD_BITS_DEF = 16;
  localparam int DIM_BITS_DEF   = 14;

  // Config register index port
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REAL_W = 2'd0,
    REG_REAL_H = 2'd1,
    REG_USER_W = 2'd2,
    REG_USER_H = 2'd3
  } cfg_idx_e;

  // Mapping direction
  typedef enum logic {
    CMD_USER2REAL = 1'b0,
    CMD_REAL2USER = 1'b1
  } cmd_e;

  // Fit sequencer states, one-hot
  typedef enum logic [3:0] {
    FS_IDLE  = 4'b0001,
    FS_MUL   = 4'b0010,
    FS_SETUP = 4'b0100,
    FS_DIV   = 4'b1000
  } fit_state_e;

  // Reset values of the config registers and the fit
  localparam int RESET_REAL_W = 1920;
  localparam int RESET_REAL_H = 1080;
  localparam int RESET_USER_W = 1920;
  localparam int RESET_USER_H = 1080;

endpackage

// ===== src/lcm_fit.sv =====
// Config registers and the letterbox fit sequencer (one shared serial divider).
// Depends on lcm_pkg.
module lcm_fit #(
  parameter int DIM_BITS = lcm_pkg::DIM_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lcm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [DIM_BITS-1:0]            cfg_data_i,
  output logic                           busy_o,
  output logic [DIM_BITS-1:0]            num_o,
  output logic [DIM_BITS-1:0]            den_o,
  output logic [DIM_BITS-1:0]            fit_w_o,
  output logic [DIM_BITS-1:0]            fit_h_o,
  output logic [DIM_BITS-1:0]            off_x_o,
  output logic [DIM_BITS-1:0]            off_y_o
);
  import lcm_pkg::*;

  localparam int D  = DIM_BITS;
  localparam int PW = 2 * D;
  localparam int CW = $clog2(PW);
  localparam logic [D-1:0] DTOP = {1'b1, {(D-1){1'b0}}};

  function automatic logic [D-1:0] dclamp(input logic [D-1:0] v);
    logic [D-1:0] r;
    r = v;
    if (v == '0) r = D'(1);
    else if (v > DTOP) r = DTOP;
    return r;
  endfunction

  fit_state_e state_q;
  logic [D-1:0] rw_q, rh_q, uw_q, uh_q;
  logic [D-1:0] rw, rh, uw, uh;
  logic [PW-1:0] p1_q, p2_q;           // rw*uh, uw*rh
  logic [PW-1:0] dvd1_q, dvd2_q;       // dividend shifting out, quotient shifting in
  logic [D-1:0]  rem1_q, rem2_q, dvs_q;
  logic          wl_q;                 // width limited
  logic [CW-1:0] cnt_q;

  logic [D:0]    r1s, r2s, r1n, r2n;
  logic          ge1, ge2;
  logic [PW-1:0] dvd1n, dvd2n;
  logic          wl;

  logic [D-1:0] num_q, den_q, fw_q, fh_q, ox_q, oy_q;

  assign rw = dclamp(rw_q);
  assign rh = dclamp(rh_q);
  assign uw = dclamp(uw_q);
  assign uh = dclamp(uh_q);
  assign wl = p1_q < p2_q;

  // one restoring step on both divisions, same divisor
  always_comb begin
    r1s   = {rem1_q, dvd1_q[PW-1]};
    r2s   = {rem2_q, dvd2_q[PW-1]};
    ge1   = r1s >= {1'b0, dvs_q};
    ge2   = r2s >= {1'b0, dvs_q};
    r1n   = ge1 ? r1s - {1'b0, dvs_q} : r1s;
    r2n   = ge2 ? r2s - {1'b0, dvs_q} : r2s;
    dvd1n = {dvd1_q[PW-2:0], ge1};
    dvd2n = {dvd2_q[PW-2:0], ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      rw_q    <= D'(RESET_REAL_W);
      rh_q    <= D'(RESET_REAL_H);
      uw_q    <= D'(RESET_USER_W);
      uh_q    <= D'(RESET_USER_H);
      num_q   <= D'(1);
      den_q   <= D'(1);
      fw_q    <= D'(RESET_REAL_W);
      fh_q    <= D'(RESET_REAL_H);
      ox_q    <= '0;
      oy_q    <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        FS_IDLE: begin
          if (cfg_we_i) begin
            unique case (cfg_idx_e'(cfg_idx_i))
              REG_REAL_W: rw_q <= cfg_data_i;
              REG_REAL_H: rh_q <= cfg_data_i;
              REG_USER_W: uw_q <= cfg_data_i;
              REG_USER_H: uh_q <= cfg_data_i;
            endcase
            state_q <= FS_MUL;
          end
        end
        FS_MUL: begin
          p1_q    <= PW'(rw) * PW'(uh);
          p2_q    <= PW'(uw) * PW'(rh);
          state_q <= FS_SETUP;
        end
        FS_SETUP: begin
          wl_q    <= wl;
          dvd1_q  <= wl ? p1_q : p2_q;
          dvd2_q  <= wl ? p2_q - p1_q : p1_q - p2_q;
          dvs_q   <= wl ? uw : uh;
          rem1_q  <= '0;
          rem2_q  <= '0;
          cnt_q   <= '0;
          state_q <= FS_DIV;
        end
        FS_DIV: begin
          dvd1_q <= dvd1n;
          dvd2_q <= dvd2n;
          rem1_q <= r1n[D-1:0];
          rem2_q <= r2n[D-1:0];
          cnt_q  <= cnt_q + CW'(1);
          if (cnt_q == CW'(PW - 1)) begin
            // offset is half the spare room: floor(floor(B/d)/2)
            if (wl_q) begin
              num_q <= rw;
              den_q <= uw;
              fw_q  <= rw;
              fh_q  <= dvd1n[D-1:0];
              ox_q  <= '0;
              oy_q  <= dvd2n[D:1];
            end else begin
              num_q <= rh;
              den_q <= uh;
              fw_q  <= dvd1n[D-1:0];
              fh_q  <= rh;
              ox_q  <= dvd2n[D:1];
              oy_q  <= '0;
            end
            state_q <= FS_IDLE;
          end
        end
      endcase
    end
  end

  assign busy_o  = state_q != FS_IDLE;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign fit_w_o = fw_q;
  assign fit_h_o = fh_q;
  assign off_x_o = ox_q;
  assign off_y_o = oy_q;

endmodule

// ===== src/lcm_lane.sv =====
// One coordinate lane: clamp, multiply, pipelined bit-per-stage divider, offset
// and saturation. Depends on lcm_pkg; stage enables come from the top level.
module lcm_lane #(
  parameter int COORD_BITS = lcm_pkg::COORD_BITS_DEF,
  parameter int DIM_BITS   = lcm_pkg::DIM_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic [COORD_BITS+DIM_BITS+1:0]      go_i,
  input  logic                                cmd_i,
  input  logic signed [COORD_BITS-1:0]        v_i,
  input  logic [DIM_BITS-1:0]                 num_i,
  input  logic [DIM_BITS-1:0]                 den_i,
  input  logic [DIM_BITS-1:0]                 off_i,
  input  logic [DIM_BITS-1:0]                 fit_i,
  output logic signed [COORD_BITS-1:0]        res_o
);
  import lcm_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int D   = DIM_BITS;
  localparam int NW  = C + D;
  localparam int LAT = NW + 2;
  localparam int EW  = ((C > D) ? C : D) + 2;
  localparam int SW  = NW + 2;

  logic [LAT-1:0] cmd_q, neg_q;
  logic [C-1:0]   m_q;
  logic [NW-1:0]  n_q;
  logic [D:0]     rem_q [NW];
  logic [NW-1:0]  nq_q  [NW];
  logic [D:0]     rem_d [NW];
  logic [NW-1:0]  nq_d  [NW];

  logic signed [EW-1:0] ve, offe, fite, t, mag;
  logic                 neg_d;
  logic [C-1:0]         m_d;
  logic [D-1:0]         a, b;
  logic [NW-1:0]        prod, n_d;

  // one restoring quotient bit; divisor is 2*b
  function automatic logic [D+NW:0] dstep(input logic [D:0] r, input logic [NW-1:0] n,
                                          input logic [D-1:0] bb);
    logic [D+1:0] rs, dv, rn;
    logic         ge;
    rs = {r, n[NW-1]};
    dv = {1'b0, bb, 1'b0};
    ge = rs >= dv;
    rn = ge ? rs - dv : rs;
    return {rn[D:0], n[NW-2:0], ge};
  endfunction

  // stage 0: real-to-user offset removal and clamp, then sign and magnitude
  always_comb begin
    ve   = EW'(v_i);
    offe = signed'(EW'(off_i));
    fite = signed'(EW'(fit_i));
    t    = ve;
    if (cmd_e'(cmd_i) == CMD_REAL2USER) begin
      t = (ve <= offe) ? '0 : ve - offe;
      if (t >= fite) t = fite - EW'(1);
    end
    neg_d = t < 0;
    mag   = neg_d ? -t : t;
    m_d   = mag[C-1:0];
  end

  // stage 1: numerator 2*m*a + b
  always_comb begin
    a    = (cmd_e'(cmd_q[0]) == CMD_REAL2USER) ? den_i : num_i;
    b    = (cmd_e'(cmd_q[0]) == CMD_REAL2USER) ? num_i : den_i;
    prod = NW'(m_q) * NW'(a);
    n_d  = (prod << 1) + NW'(b);
  end

  always_comb begin
    {rem_d[0], nq_d[0]} = dstep('0, n_q,
      (cmd_e'(cmd_q[1]) == CMD_REAL2USER) ? num_i : den_i);
    for (int k = 1; k < NW; k++) begin
      {rem_d[k], nq_d[k]} = dstep(rem_q[k-1], nq_q[k-1],
        (cmd_e'(cmd_q[k+1]) == CMD_REAL2USER) ? num_i : den_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i[0]) begin
      cmd_q[0] <= cmd_i;
      neg_q[0] <= neg_d;
      m_q      <= m_d;
    end
    for (int i = 1; i < LAT; i++) begin
      if (go_i[i]) begin
        cmd_q[i] <= cmd_q[i-1];
        neg_q[i] <= neg_q[i-1];
      end
    end
    if (go_i[1]) n_q <= n_d;
    for (int k = 0; k < NW; k++) begin
      if (go_i[k+2]) begin
        rem_q[k] <= rem_d[k];
        nq_q[k]  <= nq_d[k];
      end
    end
  end

  // sign, offset for user-to-real, saturate
  logic signed [SW-1:0] qv, sv, offa, sum;
  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (C - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] LO = -HI - SW'(1);

  always_comb begin
    qv   = signed'(SW'(nq_q[NW-1]));
    sv   = neg_q[LAT-1] ? -qv : qv;
    offa = (cmd_e'(cmd_q[LAT-1]) == CMD_USER2REAL) ? signed'(SW'(off_i)) : '0;
    sum  = sv + offa;
    if (sum > HI)      res_o = HI[C-1:0];
    else if (sum < LO) res_o = LO[C-1:0];
    else               res_o = sum[C-1:0];
  end

endmodule

// ===== src/letterbox_coordinate_mapper_top.sv =====
// Letterbox coordinate mapper top level: config port, fit unit, two lanes, output register.
// Depends on lcm_pkg, lcm_fit and lcm_lane.
//
// Maps a pointer point between an emulated user frame and the real screen, with
// the user frame fitted inside the real one at the same aspect ratio and centered.
// command 0 maps user to real (scale, round half away from zero, add offset);
// command 1 maps real to user (remove offset, clamp into the fitted area, scale
// back). Results saturate to COORD_BITS signed. Throughput is one request per
// clock while neither out_stall_i nor a fit recompute holds the input. The
// divider produces one quotient bit per pipeline stage in each of the two
// lanes (x and y). Writing a config register restarts the fit: the serial fit
// divider then holds the input stalled and cfg_ready_o low until the fit is done.
// Write configuration only while no request is in flight.
module letterbox_coordinate_mapper_top #(
  parameter int COORD_BITS = lcm_pkg::COORD_BITS_DEF,
  parameter int DIM_BITS   = lcm_pkg::DIM_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input requests
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic signed [COORD_BITS-1:0]   x_in_i,
  input  logic signed [COORD_BITS-1:0]   y_in_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [COORD_BITS-1:0]   x_out_o,
  output logic signed [COORD_BITS-1:0]   y_out_o,
  // config writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lcm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [DIM_BITS-1:0]            cfg_data_i
);
  import lcm_pkg::*;

  localparam int LAT = COORD_BITS + DIM_BITS + 2;   // lane stages before output reg

  logic                fit_busy, cfg_fire, in_fire;
  logic [DIM_BITS-1:0] num, den, fit_w, fit_h, off_x, off_y;
  logic [LAT-1:0]      vld_q;
  logic [LAT:0]        go;
  logic signed [COORD_BITS-1:0] x_res, y_res, x_out_q, y_out_q;
  logic                out_valid_q;

  assign cfg_ready_o = !fit_busy;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  lcm_fit #(.DIM_BITS(DIM_BITS)) u_fit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_fire),
    .cfg_idx_i (cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .busy_o    (fit_busy),
    .num_o     (num),
    .den_o     (den),
    .fit_w_o   (fit_w),
    .fit_h_o   (fit_h),
    .off_x_o   (off_x),
    .off_y_o   (off_y)
  );

  // Elastic pipeline: a stage loads when it is empty or something at or
  // above it frees up, so bubbles collapse and the output register can hold
  // a result while new requests keep entering.
  assign go[LAT] = !out_valid_q || !out_stall_i;
  for (genvar i = 0; i < LAT; i++) begin : g_go
    assign go[i] = go[LAT] || !(&vld_q[LAT-1:i]);
  end

  assign in_stall_o = !go[0] || fit_busy;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (go[0]) vld_q[0] <= in_fire;
      for (int i = 1; i < LAT; i++) begin
        if (go[i]) vld_q[i] <= vld_q[i-1];
      end
      if (go[LAT]) out_valid_q <= vld_q[LAT-1];
    end
  end

  lcm_lane #(.COORD_BITS(COORD_BITS), .DIM_BITS(DIM_BITS)) u_lane_x (
    .clk_i(clk_i), .go_i(go[LAT-1:0]), .cmd_i(command_i), .v_i(x_in_i),
    .num_i(num), .den_i(den), .off_i(off_x), .fit_i(fit_w), .res_o(x_res)
  );

  lcm_lane #(.COORD_BITS(COORD_BITS), .DIM_BITS(DIM_BITS)) u_lane_y (
    .clk_i(clk_i), .go_i(go[LAT-1:0]), .cmd_i(command_i), .v_i(y_in_i),
    .num_i(num), .den_i(den), .off_i(off_y), .fit_i(fit_h), .res_o(y_res)
  );

  // merge: both lanes move in lockstep, one output register for the pair
  always_ff @(posedge clk_i) begin
    if (go[LAT]) begin
      x_out_q <= x_res;
      y_out_q <= y_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_out_o     = x_out_q;
  assign y_out_o     = y_out_q;

  // a config write always blocks requests while the fit is recomputed
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> in_stall_o)
    else $error("request accepted during fit recompute");

  // a stalled result never lets the last lane stage drop its request
  a_last_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && vld_q[LAT-1]) |=> vld_q[LAT-1])
    else $error("last lane stage lost a request");

  // a new result only ever comes out of the last lane stage
  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[LAT-1]))
    else $error("result appeared without a request");

endmodule

// ===== tb/tb_letterbox_coordinate_mapper_top.sv =====
// Testbench for letterbox_coordinate_mapper_top: directed and random point requests
// checked against an in-bench model of the letterbox fit. Depends on lcm_pkg and the RTL.
`timescale 1ns / 1ps
module tb_letterbox_coordinate_mapper_top;
  import lcm_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int DB = DIM_BITS_DEF;
  localparam int LATENCY = CB + DB + 3;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = 1'b0;
  logic signed [CB-1:0] x_in = '0, y_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CB-1:0] x_out, y_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DB-1:0] cfg_data = '0;

  // Clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  letterbox_coordinate_mapper_top u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .command_i(command),
    .x_in_i(x_in), .y_in_i(y_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .x_out_o(x_out), .y_out_o(y_out),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Model state: raw registers and the derived fit
  logic [DB-1:0] dim_reg [4];
  longint off_x, off_y, fit_w, fit_h, sc_num, sc_den;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
  } point_t;
  point_t mapped_q[$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic longint clamp_dim(logic [DB-1:0] v);
    longint top;
    top = 1 << (DB - 1);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void refit();
    longint rw, rh, uw, uh;
    rw = clamp_dim(dim_reg[REG_REAL_W]);
    rh = clamp_dim(dim_reg[REG_REAL_H]);
    uw = clamp_dim(dim_reg[REG_USER_W]);
    uh = clamp_dim(dim_reg[REG_USER_H]);
    if (rw * uh < uw * rh) begin
      sc_num = rw; sc_den = uw;
      fit_w = rw; fit_h = (rw * uh) / uw;
      off_x = 0; off_y = (rh * uw - rw * uh) / (2 * uw);
    end else begin
      sc_num = rh; sc_den = uh;
      fit_w = (rh * uw) / uh; fit_h = rh;
      off_x = (rw * uh - rh * uw) / (2 * uh); off_y = 0;
    end
  endfunction

  // v*a/b, half away from zero
  function automatic longint scale_half_away(longint v, longint a, longint b);
    longint m, q;
    m = (v < 0) ? -v : v;
    q = (2 * m * a + b) / (2 * b);
    return (v < 0) ? -q : q;
  endfunction

  function automatic logic signed [CB-1:0] sat(longint v);
    longint hi, lo;
    hi = (1 <<< (CB - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CB-1:0];
  endfunction

  function automatic longint unmap_axis(longint v, longint off, longint fit);
    if (v <= off) v = 0;
    else v -= off;
    // zero fitted size ends up at -1 here
    if (v >= fit) v = fit - 1;
    return scale_half_away(v, sc_den, sc_num);
  endfunction

  function automatic point_t map_point(logic cmd, logic signed [CB-1:0] x,
                                       logic signed [CB-1:0] y);
    point_t p;
    if (cmd == CMD_USER2REAL) begin
      p.x = sat(scale_half_away(x, sc_num, sc_den) + off_x);
      p.y = sat(scale_half_away(y, sc_num, sc_den) + off_y);
    end else begin
      p.x = sat(unmap_axis(x, off_x, fit_w));
      p.y = sat(unmap_axis(y, off_y, fit_h));
    end
    return p;
  endfunction

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stall, random per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    point_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (mapped_q.size() == 0) begin
        $display("%0t unexpected result x=%0d y=%0d", $time, x_out, y_out);
        errors++;
      end else begin
        e = mapped_q.pop_front();
        if (x_out !== e.x) begin
          $display("%0t x_out expected %0d actual %0d", $time, e.x, x_out);
          errors++;
        end
        if (y_out !== e.y) begin
          $display("%0t y_out expected %0d actual %0d", $time, e.y, y_out);
          errors++;
        end
      end
    end
  end

  // Send one point request; the expectation is queued at acceptance.
  // Valid stays high after acceptance so requests can follow back to back;
  // drain() drops it at the end of a stream.
  task automatic send_point(logic cmd, logic signed [CB-1:0] x, logic signed [CB-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    x_in <= x;
    y_in <= y;
    do @(posedge clk); while (in_stall);
    mapped_q.push_back(map_point(cmd, x, y));
  endtask

  // Wait until every result is in, then let the pipeline drain
  task automatic drain();
    in_valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Register write while idle; model refits on every write
  task automatic write_dim(cfg_idx_e idx, logic [DB-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    dim_reg[idx] = val;
    refit();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frames(logic [DB-1:0] rw, logic [DB-1:0] rh,
                            logic [DB-1:0] uw, logic [DB-1:0] uh);
    drain();
    write_dim(REG_REAL_W, rw);
    write_dim(REG_REAL_H, rh);
    write_dim(REG_USER_W, uw);
    write_dim(REG_USER_H, uh);
  endtask

  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(3))
      0: return CB'($urandom);
      1: return CB'($urandom_range(0, 2000));
      2: return CB'($signed($urandom_range(0, 40)) - 20);
      default: return CB'($urandom_range(0, 9000));
    endcase
  endfunction

  // Directed: field extremes, both directions, clamps, saturation, zero fit
  task automatic test_directed();
    logic signed [CB-1:0] ext [5];
    ext = '{16'sh8000, 16'sh7fff, 0, -1, 1};
    foreach (ext[i]) begin
      send_point(CMD_USER2REAL, ext[i], ext[4 - i]);
      send_point(CMD_REAL2USER, ext[i], ext[i]);
    end
    // letterboxed: 4:3 inside 16:9, and 16:9 inside a square frame
    set_frames(1920, 1080, 640, 480);
    send_point(CMD_USER2REAL, 639, 479);
    send_point(CMD_REAL2USER, 240, 5000);
    send_point(CMD_REAL2USER, 241, -5);
    send_point(CMD_USER2REAL, -3, 16'sh7fff);
    set_frames(1024, 1024, 1920, 1080);
    send_point(CMD_REAL2USER, 1023, 100);
    send_point(CMD_USER2REAL, 1, -1);
    // zero fitted height: very wide user frame, plus zero and oversized registers
    set_frames(2, 8192, 8192, 1);
    send_point(CMD_REAL2USER, 5, 9);
    send_point(CMD_USER2REAL, 8191, 3);
    set_frames(0, 16383, 16383, 0);
    send_point(CMD_REAL2USER, 100, 100);
    send_point(CMD_USER2REAL, 16'sh7fff, 16'sh8000);
  endtask

  // Random frames and random points under the current idle mix
  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(3))
        0: set_frames(DB'($urandom), DB'($urandom), DB'($urandom), DB'($urandom));
        1: set_frames(DB'($urandom_range(1, 8192)), DB'($urandom_range(1, 8192)),
                      DB'($urandom_range(1, 8192)), DB'($urandom_range(1, 8192)));
        2: set_frames(DB'($urandom_range(1, 16)), DB'($urandom_range(1, 16)),
                      DB'($urandom_range(1, 16)), DB'($urandom_range(1, 16)));
        default: set_frames(8192, 1, 1, 8192);
      endcase
      for (int i = 0; i < per_phase; i++)
        send_point(1'($urandom_range(1)), rand_coord(), rand_coord());
    end
  endtask

  // Sender holds off until the pipeline is empty, then bursts
  task automatic test_pause_until_empty();
    drain();
    for (int i = 0; i < 10; i++)
      send_point(1'($urandom_range(1)), CB'($urandom), CB'($urandom));
  endtask

  initial begin
    dim_reg[REG_REAL_W] = RESET_REAL_W;
    dim_reg[REG_REAL_H] = RESET_REAL_H;
    dim_reg[REG_USER_W] = RESET_USER_W;
    dim_reg[REG_USER_H] = RESET_USER_H;
    refit();
    sc_num = 1; sc_den = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2 * DB + 6) @(posedge clk);

    test_directed();
    send_idle_pct = 11; recv_idle_pct = 67;
    test_random(5, 28);
    test_pause_until_empty();
    send_idle_pct = 67; recv_idle_pct = 11;
    test_random(5, 28);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(5, 28);
    test_pause_until_empty();

    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
